@@ rtl/ptrt_pkg.sv @@
// Package for the periodic task release table: sizes, codes and shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package ptrt_pkg;

   localparam int MAX_TASKS   = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int RES_W = $clog2(MAX_RESULTS + 1);

   localparam int ID_W     = 8;
   localparam int PERIOD_W = 32;

   // request operations
   localparam logic [1:0] FN_ADD  = 2'd0;
   localparam logic [1:0] FN_SET  = 2'd1;
   localparam logic [1:0] FN_TICK = 2'd2;
   localparam logic [1:0] FN_POLL = 2'd3;

   // task states
   localparam logic [1:0] TS_STOPPED = 2'd0;
   localparam logic [1:0] TS_READY   = 2'd1;
   localparam logic [1:0] TS_WAITING = 2'd2;

   // response status codes
   localparam logic [1:0] RS_OK        = 2'd0;
   localparam logic [1:0] RS_FULL      = 2'd1;
   localparam logic [1:0] RS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] counter;
      logic [1:0]          status;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0] run_id;
      logic            run_valid;
      logic [1:0]      status;
      logic            last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/periodic_task_release_table.sv @@
// Periodic task release table: top level with the walk sequencer.
// Depends on ptrt_pkg, ptrt_entry_mem and ptrt_rsp_reg.
`default_nettype none

// The block keeps up to MAX_TASKS task entries in a single-port-read,
// single-port-write memory and handles one request at a time. An add writes
// its entry on the transfer and gives its result from the finish state.
// Set-state, tick and poll walk the table from newest to oldest entry through
// the one read port, one entry per cycle unless the walk is held; a poll walk
// pauses whenever a released id cannot be handed to the output register
// because the consumer stalls. A tick gives no result and is ignored until
// the first poll. Results leave through an output register, so the last
// result of a request may still be waiting while the next request is taken.
module periodic_task_release_table
   import ptrt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_func,
   input  wire logic [ID_W-1:0]     req_task_id,
   input  wire logic [PERIOD_W-1:0] req_period,
   input  wire logic [1:0]          req_new_state,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [ID_W-1:0]          rsp_run_id,
   output logic                     rsp_run_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // request held for the walk
   logic [1:0]      op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [1:0]      nst_ff, nst_in;

   // table bookkeeping
   logic [CNT_W-1:0] count_ff, count_in;
   logic             started_ff, started_in;

   // walk pipeline: issue stage and data stage
   logic             iss_ff, iss_in;
   logic [IDX_W-1:0] iss_idx_ff, iss_idx_in;
   logic             dv_ff, dv_in;
   logic [IDX_W-1:0] d_idx_ff, d_idx_in;

   // per-request result tracking
   logic             found_ff, found_in;
   logic             pend_v_ff, pend_v_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;
   logic [RES_W-1:0] rel_cnt_ff, rel_cnt_in;
   logic [1:0]       fin_status_ff, fin_status_in;

   // memory and output register hookup
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             push;
   rsp_type          push_data;
   logic             slot_free;
   rsp_type          rsp_data;

   logic             accept;
   logic             is_rel;
   logic             consume_ok;
   logic             advance;
   logic [CNT_W-1:0] count_m1;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign count_m1  = count_ff - 1'b1;

   // a ready entry is released only while the per-poll cap has room
   assign is_rel     = (op_ff == FN_POLL) && (rd_data.status == TS_READY) &&
                       (rel_cnt_ff < RES_W'(MAX_RESULTS));
   // a release needs the output slot when an earlier id is still pending
   assign consume_ok = !(is_rel && pend_v_ff && !slot_free);
   assign advance    = !dv_ff || consume_ok;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      nst_in        = nst_ff;
      count_in      = count_ff;
      started_in    = started_ff;
      iss_in        = iss_ff;
      iss_idx_in    = iss_idx_ff;
      dv_in         = dv_ff;
      d_idx_in      = d_idx_ff;
      found_in      = found_ff;
      pend_v_in     = pend_v_ff;
      pend_id_in    = pend_id_ff;
      rel_cnt_in    = rel_cnt_ff;
      fin_status_in = fin_status_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = d_idx_ff;
      wr_data       = rd_data;
      push          = 1'b0;
      push_data     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_func;
               id_in  = req_task_id;
               nst_in = req_new_state;
               // walk starts at the newest entry
               iss_in     = 1'b1;
               iss_idx_in = count_m1[IDX_W-1:0];
               dv_in      = 1'b0;
               unique case (req_func)
                  FN_ADD: begin
                     fin_status_in = RS_OK;
                     state_in      = S_FIN;
                     if (req_task_id != '0) begin
                        if (count_ff >= CNT_W'(MAX_TASKS)) begin
                           fin_status_in = RS_FULL;
                        end else begin
                           wr_en           = 1'b1;
                           wr_addr         = count_ff[IDX_W-1:0];
                           wr_data.id      = req_task_id;
                           wr_data.period  = req_period;
                           wr_data.counter = req_period;
                           wr_data.status  = TS_READY;
                           count_in        = count_ff + 1'b1;
                        end
                     end
                  end
                  FN_SET: begin
                     fin_status_in = RS_NOT_FOUND;
                     found_in      = 1'b0;
                     if (req_task_id != '0 && count_ff != '0) begin
                        state_in = S_WALK;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
                  FN_TICK: begin
                     if (started_ff && count_ff != '0) begin
                        state_in = S_WALK;
                     end
                  end
                  FN_POLL: begin
                     fin_status_in = RS_OK;
                     started_in    = 1'b1;
                     pend_v_in     = 1'b0;
                     rel_cnt_in    = '0;
                     if (count_ff != '0) begin
                        state_in = S_WALK;
                     end else begin
                        state_in = S_FIN;
                     end
                  end
               endcase
            end
         end

         S_WALK: begin
            // data stage: modify and write back the entry read by the issue stage
            if (dv_ff && consume_ok) begin
               unique case (op_ff)
                  FN_SET: begin
                     // newest match only
                     if (!found_ff && rd_data.id == id_ff) begin
                        found_in      = 1'b1;
                        fin_status_in = RS_OK;
                        if (nst_ff == TS_STOPPED || nst_ff == TS_READY ||
                            nst_ff == TS_WAITING) begin
                           wr_en          = 1'b1;
                           wr_data.status = nst_ff;
                        end
                     end
                  end
                  FN_TICK: begin
                     // a zero counter never moves
                     if (rd_data.status == TS_WAITING && rd_data.counter != '0) begin
                        wr_en = 1'b1;
                        if (rd_data.counter == PERIOD_W'(1)) begin
                           wr_data.status  = TS_READY;
                           wr_data.counter = rd_data.period;
                        end else begin
                           wr_data.counter = rd_data.counter - 1'b1;
                        end
                     end
                  end
                  FN_POLL: begin
                     if (is_rel) begin
                        wr_en          = 1'b1;
                        wr_data.status = TS_WAITING;
                        // previous release is known not to be the last one
                        if (pend_v_ff) begin
                           push                = 1'b1;
                           push_data.run_id    = pend_id_ff;
                           push_data.run_valid = 1'b1;
                           push_data.status    = RS_OK;
                           push_data.last      = 1'b0;
                        end
                        pend_v_in  = 1'b1;
                        pend_id_in = rd_data.id;
                        rel_cnt_in = rel_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // issue stage
            if (advance) begin
               if (iss_ff) begin
                  rd_en    = 1'b1;
                  dv_in    = 1'b1;
                  d_idx_in = iss_idx_ff;
                  if (iss_idx_ff == '0) begin
                     iss_in = 1'b0;
                  end else begin
                     iss_idx_in = iss_idx_ff - 1'b1;
                  end
               end else begin
                  dv_in = 1'b0;
                  if (op_ff == FN_TICK) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end
         end

         S_FIN: begin
            if (slot_free) begin
               push             = 1'b1;
               push_data.status = fin_status_ff;
               push_data.last   = 1'b1;
               if (op_ff == FN_POLL && pend_v_ff) begin
                  push_data.run_id    = pend_id_ff;
                  push_data.run_valid = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         started_ff <= 1'b0;
         iss_ff     <= 1'b0;
         dv_ff      <= 1'b0;
         found_ff   <= 1'b0;
         pend_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         started_ff <= started_in;
         iss_ff     <= iss_in;
         dv_ff      <= dv_in;
         found_ff   <= found_in;
         pend_v_ff  <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      nst_ff        <= nst_in;
      iss_idx_ff    <= iss_idx_in;
      d_idx_ff      <= d_idx_in;
      pend_id_ff    <= pend_id_in;
      rel_cnt_ff    <= rel_cnt_in;
      fin_status_ff <= fin_status_in;
   end

   ptrt_entry_mem u_entry_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ptrt_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_run_id    = rsp_data.run_id;
   assign rsp_run_valid = rsp_data.run_valid;
   assign rsp_status    = rsp_data.status;
   assign rsp_last      = rsp_data.last;

endmodule

`default_nettype wire

@@ rtl/ptrt_entry_mem.sv @@
// Task entry store: one write port, one read port, registered read data.
// Depends on ptrt_pkg for the entry layout and depth.
`default_nettype none

module ptrt_entry_mem
   import ptrt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data
);

   entry_type mem [MAX_TASKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/ptrt_rsp_reg.sv @@
// Response output register: holds one result until the consumer takes it.
// Depends on ptrt_pkg for the response layout.
`default_nettype none

module ptrt_rsp_reg
   import ptrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         slot_free,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // slot is free when empty or when the held result transfers this cycle
   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

@@ sim/periodic_task_release_table_checker.sv @@
`timescale 1ns / 1ps
// Checker for the periodic task release table: watches both channels, keeps
// its own copy of the task table and compares every response transfer.
// Depends on ptrt_pkg; instantiated beside the block by the testbench top.

module periodic_task_release_table_checker
   import ptrt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [1:0]          req_func,
   input  wire logic [ID_W-1:0]     req_task_id,
   input  wire logic [PERIOD_W-1:0] req_period,
   input  wire logic [1:0]          req_new_state,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [ID_W-1:0]     rsp_run_id,
   input  wire logic                rsp_run_valid,
   input  wire logic [1:0]          rsp_status,
   input  wire logic                rsp_last,
   output int unsigned              mismatch_count,
   output int unsigned              releases_pending
);

   // shadow task table
   logic [ID_W-1:0]     slot_id     [MAX_TASKS];
   logic [PERIOD_W-1:0] slot_period [MAX_TASKS];
   logic [PERIOD_W-1:0] slot_count  [MAX_TASKS];
   logic [1:0]          slot_state  [MAX_TASKS];
   int                  slots_used;
   bit                  sched_running;

   rsp_type     release_q [$];
   int unsigned errors;

   initial begin
      slots_used       = 0;
      sched_running    = 0;
      errors           = 0;
      mismatch_count   = 0;
      releases_pending = 0;
   end

   task automatic apply_request(input logic [1:0] fn, input logic [ID_W-1:0] id,
                                input logic [PERIOD_W-1:0] per, input logic [1:0] nst);
      rsp_type r;
      rsp_type held;
      bit      have_held;
      bit      hit;
      int      e;
      int      n;
      r         = '0;
      r.last    = 1'b1;
      have_held = 0;
      hit       = 0;
      n         = 0;
      case (fn)
         FN_ADD: begin
            r.status = RS_OK;
            if (id != '0) begin
               if (slots_used >= MAX_TASKS) begin
                  r.status = RS_FULL;
               end else begin
                  slot_id[slots_used]     = id;
                  slot_period[slots_used] = per;
                  slot_count[slots_used]  = per;
                  slot_state[slots_used]  = TS_READY;
                  slots_used++;
               end
            end
            release_q.push_back(r);
         end
         FN_SET: begin
            r.status = RS_NOT_FOUND;
            if (id != '0) begin
               e = slots_used - 1;
               while (e >= 0 && !hit) begin
                  if (slot_id[e] == id) begin
                     // unused state code: lookup reports, state kept
                     if (nst <= TS_WAITING) slot_state[e] = nst;
                     r.status = RS_OK;
                     hit = 1;
                  end
                  e--;
               end
            end
            release_q.push_back(r);
         end
         FN_TICK: begin
            if (sched_running) begin
               for (e = 0; e < slots_used; e++) begin
                  if (slot_state[e] == TS_WAITING && slot_count[e] != '0) begin
                     slot_count[e] = slot_count[e] - 1'b1;
                     if (slot_count[e] == '0) begin
                        slot_state[e] = TS_READY;
                        slot_count[e] = slot_period[e];
                     end
                  end
               end
            end
         end
         default: begin
            sched_running = 1;
            for (e = slots_used - 1; e >= 0 && n < MAX_RESULTS; e--) begin
               if (slot_state[e] == TS_READY) begin
                  slot_state[e] = TS_WAITING;
                  if (have_held) release_q.push_back(held);
                  held           = '0;
                  held.run_id    = slot_id[e];
                  held.run_valid = 1'b1;
                  held.status    = RS_OK;
                  have_held      = 1;
                  n++;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               release_q.push_back(held);
            end else begin
               release_q.push_back(r);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (release_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected response id=%0d valid=%0b status=%0d last=%0b",
                           $realtime, rsp_run_id, rsp_run_valid, rsp_status, rsp_last);
            end else begin
               want = release_q.pop_front();
               if (rsp_run_id !== want.run_id || rsp_run_valid !== want.run_valid ||
                   rsp_status !== want.status || rsp_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: response differs: exp id=%0d valid=%0b status=%0d last=%0b, got id=%0d valid=%0b status=%0d last=%0b",
                              $realtime, want.run_id, want.run_valid, want.status,
                              want.last, rsp_run_id, rsp_run_valid, rsp_status,
                              rsp_last);
               end
            end
         end
         if (req_valid && !req_stall)
            apply_request(req_func, req_task_id, req_period, req_new_state);
      end
      mismatch_count   <= errors;
      releases_pending <= release_q.size();
   end

endmodule

@@ sim/periodic_task_release_table_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the periodic task release table: clock, reset, request
// stimulus, response back-pressure, watchdog and verdict.
// Depends on ptrt_pkg, the block and periodic_task_release_table_checker.

module periodic_task_release_table_tb;
   import ptrt_pkg::*;

   localparam int RANDOM_ITEMS = 460;
   localparam int IDLE_LIMIT   = 3000;  // cycles without any transfer
   localparam int SETTLE_WAIT  = 40;    // a full-table walk plus the output register
   localparam int LONG_HOLD    = 400;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func      = FN_TICK;
   logic [ID_W-1:0]     req_task_id   = '0;
   logic [PERIOD_W-1:0] req_period    = '0;
   logic [1:0]          req_new_state = TS_STOPPED;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [ID_W-1:0]     rsp_run_id;
   logic                rsp_run_valid;
   logic [1:0]          rsp_status;
   logic                rsp_last;

   int unsigned mismatch_total;
   int unsigned releases_pending;

   // sender burst bookkeeping and the ids handed out so far (set-state targets)
   int              burst_left = 0;
   logic [ID_W-1:0] issued_ids [$];

   always #6 clock = ~clock;

   periodic_task_release_table dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_task_id   (req_task_id),
      .req_period    (req_period),
      .req_new_state (req_new_state),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_run_id    (rsp_run_id),
      .rsp_run_valid (rsp_run_valid),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   periodic_task_release_table_checker watcher (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_period       (req_period),
      .req_new_state    (req_new_state),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_run_id       (rsp_run_id),
      .rsp_run_valid    (rsp_run_valid),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_total),
      .releases_pending (releases_pending)
   );

   // Offer one request and hold it until the transfer. Requests go out in
   // bursts; between bursts valid may drop for a random gap. Inside a burst
   // valid stays high, so it never gets a second assignment in one step.
   task automatic offer(input logic [1:0] fn, input logic [ID_W-1:0] id,
                        input logic [PERIOD_W-1:0] per, input logic [1:0] nst);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid     <= 1'b1;
      req_func      <= fn;
      req_task_id   <= id;
      req_period    <= per;
      req_new_state <= nst;
      if (fn == FN_ADD && id != '0) issued_ids.push_back(id);
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // Pause the sender until every predicted response has come back. The
   // first edge is taken before looking, as the checker's count is registered.
   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (releases_pending != 0);
   endtask

   // Receiver: back-pressure in phases of its own. One phase is a long hold,
   // during which the sender keeps offering so the block fills and stalls.
   initial begin : receiver
      int phase;
      int mode;
      int span;
      phase = 0;
      wait (!reset);
      forever begin
         mode = (phase == 10) ? 4 : $urandom_range(0, 3);
         span = (mode == 4) ? LONG_HOLD : $urandom_range(20, 150);
         repeat (span) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               3:       rsp_stall <= ~rsp_stall;
               default: rsp_stall <= 1'b1;
            endcase
            @(posedge clock);
         end
         phase++;
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("periodic_task_release_table: mismatch");
      $finish;
   end

   initial begin : stimulus
      int              k;
      int              pick;
      logic [1:0]      fn;
      logic [ID_W-1:0] id;
      logic [PERIOD_W-1:0] per;
      logic [1:0]      nst;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      offer(FN_TICK, 8'd0, '0, TS_STOPPED);         // tick before start: ignored
      offer(FN_ADD,  8'd0, 32'd3, TS_STOPPED);      // reserved id on add
      offer(FN_SET,  8'd0, '0, TS_READY);           // reserved id on set state
      offer(FN_POLL, 8'd0, '0, TS_STOPPED);         // empty poll, starts scheduler
      offer(FN_ADD,  8'd255, 32'hFFFF_FFFF, TS_STOPPED);
      offer(FN_ADD,  8'd1, 32'd0, TS_STOPPED);      // zero period: never moves once waiting
      offer(FN_ADD,  8'd7, 32'd2, TS_STOPPED);
      offer(FN_ADD,  8'd7, 32'd1, TS_STOPPED);      // duplicate id
      offer(FN_SET,  8'd7, '0, 2'd3);               // unused state code
      offer(FN_SET,  8'd7, '0, TS_STOPPED);         // hits the newest id 7 only
      offer(FN_POLL, 8'd0, '0, TS_STOPPED);         // releases 7, 1, 255
      offer(FN_TICK, 8'd0, '0, TS_STOPPED);
      offer(FN_TICK, 8'd0, '0, TS_STOPPED);         // older id 7 reloads, ready again
      offer(FN_POLL, 8'd0, '0, TS_STOPPED);
      for (k = 4; k < MAX_TASKS; k++)
         offer(FN_ADD, 8'($urandom_range(1, 12)), 32'($urandom_range(1, 5)),
               TS_STOPPED);
      offer(FN_ADD,  8'd200, 32'd4, TS_STOPPED);    // table full
      offer(FN_POLL, 8'hFF, 32'hFFFF_FFFF, 2'd3);   // a wide release
      settle();

      // --- random part ---
      // Mostly ticks and polls over the live table, set-state aimed at ids in
      // use, and some noise: reserved or unknown ids and adds to a full table.
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) settle();
         pick = $urandom_range(0, 99);
         id   = 8'($urandom_range(0, 255));
         per  = $urandom;
         nst  = 2'($urandom_range(0, 3));
         if (pick < 12) begin
            fn = FN_ADD;
            if ($urandom_range(0, 3) != 0) per = 32'($urandom_range(0, 6));
         end else if (pick < 32) begin
            fn = FN_SET;
            if ($urandom_range(0, 9) < 8 && issued_ids.size() > 0)
               id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
         end else if (pick < 72) begin
            fn = FN_TICK;
         end else begin
            fn = FN_POLL;
         end
         offer(fn, id, per, nst);
      end

      settle();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_total == 0 && releases_pending == 0)
         $display("periodic_task_release_table: match");
      else
         $display("periodic_task_release_table: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ptrt_pkg.sv
rtl/ptrt_entry_mem.sv
rtl/ptrt_rsp_reg.sv
rtl/periodic_task_release_table.sv
sim/periodic_task_release_table_checker.sv
sim/periodic_task_release_table_tb.sv
